// ===== sv/bacs_pkg.sv =====
// ---------------------------------------------------------------------------
// bacs_pkg
// Shared types and constants for the bit-addressed coil store.
// ---------------------------------------------------------------------------
`default_nettype none

package bacs_pkg;

   localparam int STORE_BYTES_DEF = 32;

   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 11;
   localparam int BYTE_W  = 8;
   localparam int SLOT_W  = 8;
   localparam int OFF_W   = 3;
   localparam int IDX_W   = 14;

   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_NO_REGISTER = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_COMMIT
   } bacs_state_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic commit;
   } bacs_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } bacs_sts_type;

endpackage

`default_nettype wire

// ===== sv/bacs_ctrl.sv =====
// ---------------------------------------------------------------------------
// bacs_ctrl
// Sequencer: takes a beat, fetches the two store bytes, then commits.
// ---------------------------------------------------------------------------
`default_nettype none

module bacs_ctrl
   import bacs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire bacs_sts_type sts,
   output      bacs_cmd_type cmd
);

   bacs_state_type state_ff;
   bacs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!sts.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/bacs_dpath.sv =====
// ---------------------------------------------------------------------------
// bacs_dpath
// Range check, slot tracking, two-bank coil store and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bacs_dpath
   import bacs_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bacs_cmd_type       cmd,
   output      bacs_sts_type       sts,
   input  wire logic               req_func,
   input  wire logic [ADDR_W-1:0]  req_start_coil,
   input  wire logic [COUNT_W-1:0] req_coil_count,
   input  wire logic [BYTE_W-1:0]  req_write_byte,
   input  wire logic               csr_wr_en,
   input  wire logic [ADDR_W-1:0]  csr_wr_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [BYTE_W-1:0]  rsp_read_byte,
   output      logic               rsp_status,
   output      logic               rsp_last_byte
);

   localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [ADDR_W:0]  STORE_COILS = (ADDR_W + 1)'(STORE_BYTES * 8);
   localparam logic [IDX_W-1:0] STORE_LIM   = IDX_W'(STORE_BYTES);

   // configuration and slot state
   logic [ADDR_W-1:0] coil_base_ff;
   logic [SLOT_W-1:0] slot_pos_ff;
   logic [SLOT_W-1:0] slot_pos_in;

   // captured beat
   logic               func_ff;
   logic [ADDR_W-1:0]  start_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [BYTE_W-1:0]  wbyte_ff;

   // fetch results
   logic               err_ff;
   logic               active_ff;
   logic               last_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [BYTE_W-1:0]  nmask_ff;
   logic               idx0_ff;
   logic               even_ok_ff;
   logic               odd_ok_ff;
   logic [BANK_AW-1:0] even_addr_ff;
   logic [BANK_AW-1:0] odd_addr_ff;
   logic [BYTE_W-1:0]  even_rd_ff;
   logic [BYTE_W-1:0]  odd_rd_ff;

   // store
   logic [BYTE_W-1:0]     even_mem [BANK_DEPTH];
   logic [BYTE_W-1:0]     odd_mem  [BANK_DEPTH];
   logic [BANK_DEPTH-1:0] even_vld_ff;
   logic [BANK_DEPTH-1:0] odd_vld_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_status_ff;
   logic              rsp_last_ff;

   // fetch-stage logic
   logic [ADDR_W:0]    end_sum;
   logic [ADDR_W:0]    limit;
   logic               err;
   logic [COUNT_W:0]   cnt_ext;
   logic [COUNT_W:0]   done_coils;
   logic [COUNT_W:0]   remain;
   logic [3:0]         n_coils;
   logic [BYTE_W-1:0]  nmask;
   logic [SLOT_W:0]    slots;
   logic [SLOT_W:0]    k_next;
   logic               last;
   logic [ADDR_W-1:0]  rel;
   logic [IDX_W-1:0]   idx;
   logic [IDX_W-1:0]   idx_p1;
   logic [IDX_W-1:0]   even_byte;
   logic               lo_ok;
   logic               hi_ok;
   logic               even_ok;
   logic               odd_ok;
   logic [BANK_AW-1:0] even_addr;
   logic [BANK_AW-1:0] odd_addr;

   // commit-stage logic
   logic [BYTE_W-1:0]   lo_byte;
   logic [BYTE_W-1:0]   hi_byte;
   logic [2*BYTE_W-1:0] pair;
   logic [2*BYTE_W-1:0] pair_sh;
   logic [2*BYTE_W-1:0] mask16;
   logic [2*BYTE_W-1:0] data16;
   logic [BYTE_W-1:0]   new_lo;
   logic [BYTE_W-1:0]   new_hi;
   logic [BYTE_W-1:0]   rd_bits;
   logic                wr_go;
   logic                even_we;
   logic                odd_we;
   logic [BYTE_W-1:0]   even_wd;
   logic [BYTE_W-1:0]   odd_wd;

   always_comb begin
      end_sum    = {1'b0, start_ff} + (ADDR_W + 1)'(count_ff);
      limit      = {1'b0, coil_base_ff} + STORE_COILS;
      err        = (start_ff < coil_base_ff) || (end_sum > limit);

      cnt_ext    = {1'b0, count_ff};
      done_coils = (COUNT_W + 1)'({slot_pos_ff, 3'b000});
      remain     = cnt_ext - done_coils;
      if (cnt_ext <= done_coils) begin
         n_coils = 4'd0;
      end else if (remain > (COUNT_W + 1)'(8)) begin
         n_coils = 4'd8;
      end else begin
         n_coils = remain[3:0];
      end
      if (n_coils == 4'd8) begin
         nmask = BYTE_ONES;
      end else begin
         nmask = BYTE_W'((9'd1 << n_coils) - 9'd1);
      end

      slots  = (SLOT_W + 1)'((cnt_ext + (COUNT_W + 1)'(7)) >> 3);
      if (slots == '0) begin
         slots = (SLOT_W + 1)'(1);
      end
      k_next = {1'b0, slot_pos_ff} + (SLOT_W + 1)'(1);
      last   = (k_next >= slots);

      rel       = start_ff - coil_base_ff;
      idx       = IDX_W'(rel[ADDR_W-1:3]) + IDX_W'(slot_pos_ff);
      idx_p1    = idx + IDX_W'(1);
      even_byte = idx + IDX_W'(idx[0]);
      lo_ok     = (idx < STORE_LIM);
      hi_ok     = (idx_p1 < STORE_LIM);
      even_ok   = idx[0] ? hi_ok : lo_ok;
      odd_ok    = idx[0] ? lo_ok : hi_ok;
      even_addr = even_byte[BANK_AW:1];
      odd_addr  = idx[BANK_AW:1];
   end

   always_comb begin
      lo_byte = idx0_ff ? odd_rd_ff : even_rd_ff;
      hi_byte = idx0_ff ? even_rd_ff : odd_rd_ff;
      pair    = {hi_byte, lo_byte};
      pair_sh = pair >> off_ff;
      rd_bits = pair_sh[BYTE_W-1:0] & nmask_ff;
      mask16  = {{BYTE_W{1'b0}}, nmask_ff} << off_ff;
      data16  = {{BYTE_W{1'b0}}, wbyte_ff & nmask_ff} << off_ff;
      new_lo  = (lo_byte & ~mask16[BYTE_W-1:0]) | data16[BYTE_W-1:0];
      new_hi  = (hi_byte & ~mask16[2*BYTE_W-1:BYTE_W]) | data16[2*BYTE_W-1:BYTE_W];
      wr_go   = cmd.commit && active_ff && (func_ff == FUNC_WRITE);
      even_we = wr_go && even_ok_ff;
      odd_we  = wr_go && odd_ok_ff;
      even_wd = idx0_ff ? new_hi : new_lo;
      odd_wd  = idx0_ff ? new_lo : new_hi;

      slot_pos_in = slot_pos_ff;
      if (cmd.commit) begin
         slot_pos_in = last_ff ? '0 : slot_pos_ff + SLOT_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      sts.out_blocked = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_base_ff <= '0;
         slot_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         even_vld_ff  <= '0;
         odd_vld_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            coil_base_ff <= csr_wr_data;
         end
         slot_pos_ff  <= slot_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (even_we) begin
            even_vld_ff[even_addr_ff] <= 1'b1;
         end
         if (odd_we) begin
            odd_vld_ff[odd_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         start_ff <= req_start_coil;
         count_ff <= req_coil_count;
         wbyte_ff <= req_write_byte;
      end
      if (cmd.fetch) begin
         err_ff       <= err;
         active_ff    <= !err && (n_coils != 4'd0);
         last_ff      <= last;
         off_ff       <= rel[OFF_W-1:0];
         nmask_ff     <= nmask;
         idx0_ff      <= idx[0];
         even_ok_ff   <= even_ok;
         odd_ok_ff    <= odd_ok;
         even_addr_ff <= even_addr;
         odd_addr_ff  <= odd_addr;
         even_rd_ff   <= (even_ok && even_vld_ff[even_addr]) ? even_mem[even_addr] : '0;
         odd_rd_ff    <= (odd_ok && odd_vld_ff[odd_addr]) ? odd_mem[odd_addr] : '0;
      end
      if (even_we) begin
         even_mem[even_addr_ff] <= even_wd;
      end
      if (odd_we) begin
         odd_mem[odd_addr_ff] <= odd_wd;
      end
      if (cmd.commit) begin
         rsp_byte_ff   <= (active_ff && (func_ff == FUNC_READ)) ? rd_bits : '0;
         rsp_status_ff <= err_ff ? STATUS_NO_REGISTER : STATUS_OK;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/bit_addressed_coil_store.sv =====
// ---------------------------------------------------------------------------
// bit_addressed_coil_store
// Coil store read or written one packed byte slot per beat.
//
// A request arrives as one req_ beat per byte slot, each carrying the same
// func, start_coil and coil_count; write slots also carry write_byte. Every
// beat gives exactly one rsp_ beat: read_byte, status (no_register when the
// range falls outside the store) and last_byte on the final slot.
// csr_wr_en/csr_wr_data load coil_base; write it only while idle.
// A beat is captured in IDLE, the store is read in FETCH and the result is
// registered in COMMIT; no new beat is taken until the last one commits.
// The store reads the even and odd byte banks in FETCH and writes them back
// in COMMIT.
// Reset clears coil_base, the slot position and every coil at once.
// When rsp_ready is low the result stays in the output register; one more
// request beat is taken and held until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module bit_addressed_coil_store
   import bacs_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_func,
   input  wire logic [ADDR_W-1:0]  req_start_coil,
   input  wire logic [COUNT_W-1:0] req_coil_count,
   input  wire logic [BYTE_W-1:0]  req_write_byte,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [BYTE_W-1:0]  rsp_read_byte,
   output      logic               rsp_status,
   output      logic               rsp_last_byte,
   input  wire logic               csr_wr_en,
   input  wire logic [ADDR_W-1:0]  csr_wr_data
);

   bacs_cmd_type cmd;
   bacs_sts_type sts;

   bacs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bacs_dpath #(
      .STORE_BYTES (STORE_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_start_coil (req_start_coil),
      .req_coil_count (req_coil_count),
      .req_write_byte (req_write_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_status     (rsp_status),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

`default_nettype wire

// ===== tb/tb_bit_addressed_coil_store.sv =====
// ---------------------------------------------------------------------------
// tb_bit_addressed_coil_store
// Self-checking bench for the bit-addressed coil store.
//
// Requests go in as req_ beats, one byte slot per beat. A scoreboard keeps
// its own copy of the coil image, the slot position and coil_base. It works
// out the read_byte, status and last_byte that each accepted beat must
// produce, and compares every rsp_ beat against the oldest pending result.
// A short directed sequence covers aligned and unaligned access, the top
// coil, zero counts, out-of-range requests and a count change mid-request.
// Random traffic then runs under several coil_base settings, the extremes
// among them. Most of it is well-formed requests; the rest is out-of-range
// requests and raw noise. Both channels see random gaps, and one phase runs
// without any.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bit_addressed_coil_store;
   import bacs_pkg::*;

   localparam int STORE_BYTES = STORE_BYTES_DEF;
   localparam int COILS       = STORE_BYTES * 8;
   localparam int IDLE_LIMIT  = 1000;
   localparam int PHASE_BEATS = 270;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              status;
      logic              last_byte;
   } coil_result_type;

   class coil_scoreboard_type;
      logic [BYTE_W-1:0] coil_image [STORE_BYTES];
      int unsigned       slot_pos;
      int unsigned       coil_base;
      coil_result_type   pending_results [$];
      int                errors;
      int                n_in;
      int                n_reads;
      int                n_writes;
      int                n_rejected;

      function new();
         foreach (coil_image[i]) coil_image[i] = '0;
         slot_pos   = 0;
         coil_base  = 0;
         errors     = 0;
         n_in       = 0;
         n_reads    = 0;
         n_writes   = 0;
         n_rejected = 0;
      endfunction

      function void set_base(logic [ADDR_W-1:0] value);
         coil_base = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function logic [BYTE_W-1:0] byte_at(int unsigned idx);
         if (idx < STORE_BYTES) return coil_image[idx];
         return '0;
      endfunction

      function void merge_byte(int unsigned idx, logic [BYTE_W-1:0] mask,
                               logic [BYTE_W-1:0] data);
         if (idx < STORE_BYTES)
            coil_image[idx] = (coil_image[idx] & ~mask) | (data & mask);
      endfunction

      // One accepted slot: predict its result and apply any coil update.
      function void note_request(logic func, logic [ADDR_W-1:0] start,
                                 logic [COUNT_W-1:0] count, logic [BYTE_W-1:0] wbyte);
         int unsigned       st, cnt, slots, k, n, rel, idx, off;
         logic [BYTE_W-1:0] nmask;
         logic [15:0]       pair, wmask, wdata;
         coil_result_type   res;
         st    = start;
         cnt   = count;
         slots = (cnt + 7) / 8;
         if (slots == 0) slots = 1;
         k     = slot_pos;
         res   = '0;
         res.last_byte = (k + 1 >= slots);
         n = 0;
         if (cnt > 8 * k) begin
            n = cnt - 8 * k;
            if (n > 8) n = 8;
         end
         if (st < coil_base || st + cnt > coil_base + COILS) begin
            res.status = STATUS_NO_REGISTER;
            n_rejected++;
         end else if (n > 0) begin
            rel   = st - coil_base;
            idx   = rel / 8 + k;
            off   = rel % 8;
            nmask = BYTE_W'((1 << n) - 1);
            if (func == FUNC_READ) begin
               pair = {byte_at(idx + 1), byte_at(idx)};
               res.read_byte = BYTE_W'(pair >> off) & nmask;
               n_reads++;
            end else begin
               wmask = 16'(nmask) << off;
               wdata = 16'(wbyte & nmask) << off;
               merge_byte(idx, wmask[7:0], wdata[7:0]);
               merge_byte(idx + 1, wmask[15:8], wdata[15:8]);
               n_writes++;
            end
         end
         slot_pos = res.last_byte ? 0 : (k + 1) & 'hFF;
         pending_results.push_back(res);
         n_in++;
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH: %s", msg);
      endtask

      task check_result(logic [BYTE_W-1:0] rbyte, logic status, logic last);
         coil_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no result pending");
         end else begin
            want = pending_results.pop_front();
            if (rbyte !== want.read_byte)
               report_mismatch($sformatf("read_byte %02h, expected %02h",
                                         rbyte, want.read_byte));
            if (status !== want.status)
               report_mismatch($sformatf("status %b, expected %b", status, want.status));
            if (last !== want.last_byte)
               report_mismatch($sformatf("last_byte %b, expected %b",
                                         last, want.last_byte));
         end
      endtask
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic               req_func       = FUNC_READ;
   logic [ADDR_W-1:0]  req_start_coil = '0;
   logic [COUNT_W-1:0] req_coil_count = '0;
   logic [BYTE_W-1:0]  req_write_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [BYTE_W-1:0]  rsp_read_byte;
   logic               rsp_status;
   logic               rsp_last_byte;
   logic               csr_wr_en      = 1'b0;
   logic [ADDR_W-1:0]  csr_wr_data    = '0;

   bit                  steady        = 1'b0;
   int                  idle_cycles   = 0;
   int                  n_bases       = 0;
   coil_scoreboard_type sb            = new();

   bit_addressed_coil_store #(.STORE_BYTES(STORE_BYTES)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_start_coil (req_start_coil),
      .req_coil_count (req_coil_count),
      .req_write_byte (req_write_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_status     (rsp_status),
      .rsp_last_byte  (rsp_last_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result side: random backpressure
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_read_byte, rsp_status, rsp_last_byte);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL bit_addressed_coil_store");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic func, input logic [ADDR_W-1:0] start,
                            input logic [COUNT_W-1:0] count,
                            input logic [BYTE_W-1:0] wbyte);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_start_coil <= start;
      req_coil_count <= count;
      req_write_byte <= wbyte;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, start, count, wbyte);
   endtask

   // whole request, one beat per slot; fill < 0 gives random write data
   task automatic send_request(input logic func, input int unsigned start,
                               input int unsigned count, input int fill);
      int unsigned slots;
      slots = (count + 7) / 8;
      if (slots == 0) slots = 1;
      repeat (slots)
         send_beat(func, ADDR_W'(start), COUNT_W'(count),
                   (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(input logic [ADDR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_base(value);
      n_bases++;
   endtask

   task automatic rand_request(input int unsigned base);
      int unsigned room, count, start, c, r;
      logic        func;
      room = 65536 - base;
      if (room > COILS) room = COILS;
      func = 1'($urandom);
      r    = $urandom_range(0, 99);
      if (r < 70) begin
         c = $urandom_range(0, 19);
         if (c == 0) count = 0;
         else if (c < 14) count = $urandom_range(1, (room < 16) ? room : 16);
         else count = $urandom_range(1, room);
         start = base + $urandom_range(0, room - count);
         send_request(func, start, count, -1);
      end else if (r < 85) begin
         if ($urandom_range(0, 49) == 0) count = $urandom_range(COILS + 1, 2047);
         else count = $urandom_range(1, 16);
         if (base > 0 && $urandom_range(0, 1))
            start = base - $urandom_range(1, (base < 16) ? base : 16);
         else
            start = (base + COILS - count + $urandom_range(1, 8)) & 'hFFFF;
         send_request(func, start, count, -1);
      end else begin
         send_beat(1'($urandom), ADDR_W'($urandom), COUNT_W'($urandom), BYTE_W'($urandom));
         if ($urandom_range(0, 1))
            send_beat(1'($urandom), ADDR_W'($urandom), '0, BYTE_W'($urandom));
      end
   endtask

   initial begin
      int unsigned bases [6];
      int          first;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, coil_base at its reset value
      send_request(FUNC_WRITE, 0, 8, 'hA5);
      send_request(FUNC_READ, 0, 8, 0);
      send_request(FUNC_WRITE, 3, 13, 'hFF);
      send_request(FUNC_READ, 0, 16, 0);
      send_request(FUNC_READ, 3, 13, 0);
      send_request(FUNC_READ, 0, 0, 0);
      send_request(FUNC_WRITE, 5, 0, 'hFF);
      send_request(FUNC_WRITE, COILS - 1, 1, 'hFF);
      send_request(FUNC_READ, COILS - 8, 8, 0);
      send_request(FUNC_READ, COILS - 6, 10, 0);
      send_request(FUNC_WRITE, 'hFFFF, 1, 'hFF);
      send_beat(FUNC_READ, 0, 24, 8'h00);
      send_beat(FUNC_READ, 0, 8, 8'h00);
      send_beat(FUNC_READ, 0, 11'h7FF, 8'h00);
      send_beat(FUNC_WRITE, 0, 0, 8'hFF);
      send_request(FUNC_READ, 7, 9, 0);
      send_request(FUNC_WRITE, 1, 6, 0);

      bases[0] = 0;
      bases[1] = 'hFFFF;
      bases[2] = 'hFF00;
      bases[3] = $urandom_range(1, 'hFEFF);
      bases[4] = $urandom_range(1, 300);
      bases[5] = 0;
      foreach (bases[p]) begin
         drain();
         write_base(ADDR_W'(bases[p]));
         steady = (p == 5);
         first  = sb.n_in;
         while (sb.n_in - first < PHASE_BEATS) rand_request(bases[p]);
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      $display("covered %0d request beats under %0d coil_base settings",
               sb.n_in, n_bases);
      $display("  %0d coil reads, %0d coil writes, %0d out-of-range slots",
               sb.n_reads, sb.n_writes, sb.n_rejected);
      if (sb.errors == 0) begin
         $display("PASS bit_addressed_coil_store");
      end else begin
         $display("FAIL bit_addressed_coil_store");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bacs_pkg.sv
sv/bacs_ctrl.sv
sv/bacs_dpath.sv
sv/bit_addressed_coil_store.sv
tb/tb_bit_addressed_coil_store.sv
